### src/sysres_pkg.sv
// Package for the systematic resampler: constants and the sequencer state type.
package sysres_pkg;

  // Largest particle count the storage is built for.
  localparam int MAX_PARTICLES_DEF = 64;

  // Fixed field widths.
  localparam int CFG_W    = 7;   // particle_count register
  localparam int WEIGHT_W = 17;  // Q1.16 weight, 65536 is one
  localparam int DRAW_W   = 16;  // Q0.16 uniform draw
  localparam int SRC_W    = 6;   // source_index field
  localparam int SUM_W    = 23;  // cumulative weight entry

  // Q0.16 constants.
  localparam int ONE_Q16  = 65536;
  localparam int HALF_Q16 = 32768;

  // Reset value of the particle count register.
  localparam int COUNT_RESET = 64;

  typedef enum logic [2:0] {
    ST_IDLE,   // loading weights
    ST_READ,   // read cumulative entry at the walk pointer
    ST_MUL,    // scale the entry by N
    ST_CMP,    // compare the slot threshold with the scaled entry
    ST_EMIT    // hand the slot's index to the output register
  } st_t;

endpackage

### src/systematic_resampler.sv
// Systematic resampler: weight loader, cumulative weight memory and pointer walk sequencer.
//
// Weights arrive one per input transfer and are summed into a cumulative weight
// memory; the block takes a new weight in every cycle while loading.
// The transfer marked last_in also brings the uniform draw and starts the walk, during
// which in_stall stays high. For each output slot j the walk compares the threshold
// draw - 0.5 + j (in Q0.16, kept in a register and stepped by one per slot) with N times
// the cumulative weight at the walk pointer, and moves the pointer forward while the
// threshold is larger and the pointer is below N-1. One shared path does this: a read
// of the weight memory, a registered multiply by N and a compare for each test, then
// an emit step that places each result in the output register and waits while the
// output side stalls. The user must write the particle count N over the cfg port only
// while the block is idle; the block itself does not enforce this. Zero acts as one and
// values above MAX_PARTICLES act as MAX_PARTICLES. Missing weights count as zero, and
// weights beyond N in a set are ignored.
module systematic_resampler #(
  parameter int MAX_PARTICLES = sysres_pkg::MAX_PARTICLES_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  // weight input channel
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [sysres_pkg::WEIGHT_W-1:0] in_weight,
  input  logic [sysres_pkg::DRAW_W-1:0]   in_draw,
  input  logic                         in_last_in,
  // resampled index output channel
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [sysres_pkg::SRC_W-1:0] out_source_index,
  output logic                         out_last_out,
  // particle count configuration
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [sysres_pkg::CFG_W-1:0] cfg_particle_count
);
  import sysres_pkg::*;

  localparam int IDX_W  = $clog2(MAX_PARTICLES);
  localparam int CNT_W  = $clog2(MAX_PARTICLES + 1);
  localparam int LHS_W  = CNT_W + WEIGHT_W;
  localparam int PROD_W = CNT_W + SUM_W;

  // Cumulative weight memory: one write port for the loader, one read port for the walk.
  logic [SUM_W-1:0] mem [MAX_PARTICLES];

  st_t                      state_r, state_nxt;
  logic [CFG_W-1:0]         count_r;
  logic [CNT_W-1:0]         load_r;
  logic [SUM_W-1:0]         sum_r;
  logic [CNT_W-1:0]         cnt_r;
  logic [IDX_W-1:0]         wp_r;
  logic [IDX_W-1:0]         slot_r;
  logic signed [LHS_W-1:0]  lhs_r;
  logic [SUM_W-1:0]         rdata_r;
  logic [PROD_W-1:0]        prod_r;
  logic                     out_valid_r;
  logic [SRC_W-1:0]         out_idx_r;
  logic                     out_last_r;

  logic [CNT_W-1:0]         n_eff;
  logic [CNT_W-1:0]         n_last;
  logic                     in_xfer;
  logic [WEIGHT_W-1:0]      w_sat;
  logic [SUM_W-1:0]         sum_base;
  logic [SUM_W-1:0]         sum_nxt;
  logic                     store;
  logic [CNT_W-1:0]         load_after;
  logic [IDX_W-1:0]         rd_addr;
  logic                     lhs_gt;
  logic                     advance;
  logic                     out_free;
  logic                     slot_last;

  // Effective particle count, clamped to the range the storage supports.
  always_comb begin
    if (count_r == '0) begin
      n_eff = CNT_W'(1);
    end else if (count_r > CFG_W'(MAX_PARTICLES)) begin
      n_eff = CNT_W'(MAX_PARTICLES);
    end else begin
      n_eff = CNT_W'(count_r);
    end
    n_last = n_eff - CNT_W'(1);
  end

  assign cfg_ready = 1'b1;
  assign in_stall  = (state_r != ST_IDLE);
  assign in_xfer   = in_valid && !in_stall;

  // Loader datapath: saturate the weight and extend the running sum.
  assign w_sat      = (in_weight > WEIGHT_W'(ONE_Q16)) ? WEIGHT_W'(ONE_Q16) : in_weight;
  assign sum_base   = (load_r == '0) ? '0 : sum_r;
  assign sum_nxt    = sum_base + SUM_W'(w_sat);
  assign store      = in_xfer && (load_r < n_eff);
  assign load_after = store ? load_r + CNT_W'(1) : load_r;

  // Walk datapath. Entries past the loaded ones read as the last loaded entry.
  assign rd_addr   = (CNT_W'(wp_r) < cnt_r) ? wp_r : IDX_W'(cnt_r - CNT_W'(1));
  assign lhs_gt    = !lhs_r[LHS_W-1] && (PROD_W'($unsigned(lhs_r)) > prod_r);
  assign advance   = lhs_gt && (CNT_W'(wp_r) < n_last);
  assign out_free  = !out_valid_r || !out_stall;
  assign slot_last = (CNT_W'(slot_r) == n_last);

  always_ff @(posedge clk) begin
    if (store) begin
      mem[load_r[IDX_W-1:0]] <= sum_nxt;
    end
    if (state_r == ST_READ) begin
      rdata_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_xfer && in_last_in) begin
          state_nxt = ST_READ;
        end
      end
      ST_READ: begin
        state_nxt = ST_MUL;
      end
      ST_MUL: begin
        state_nxt = ST_CMP;
      end
      ST_CMP: begin
        state_nxt = advance ? ST_READ : ST_EMIT;
      end
      ST_EMIT: begin
        if (out_free) begin
          state_nxt = slot_last ? ST_IDLE : ST_READ;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers of the loader and the walk.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= CFG_W'(COUNT_RESET);
      load_r      <= '0;
      wp_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        count_r <= cfg_particle_count;
      end
      if (in_xfer) begin
        load_r <= in_last_in ? '0 : load_after;
        if (in_last_in) begin
          wp_r <= '0;
        end
      end
      if (state_r == ST_CMP && advance) begin
        wp_r <= wp_r + IDX_W'(1);
      end
      if (state_r == ST_EMIT && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (store) begin
      sum_r <= sum_nxt;
    end
    if (in_xfer && in_last_in) begin
      cnt_r  <= (load_after < n_eff) ? load_after : n_eff;
      slot_r <= '0;
      lhs_r  <= signed'(LHS_W'(in_draw)) - signed'(LHS_W'(HALF_Q16));
    end
    if (state_r == ST_MUL) begin
      prod_r <= PROD_W'(n_eff) * PROD_W'(rdata_r);
    end
    if (state_r == ST_EMIT && out_free) begin
      out_idx_r  <= SRC_W'(wp_r);
      out_last_r <= slot_last;
      slot_r     <= slot_r + IDX_W'(1);
      lhs_r      <= lhs_r + signed'(LHS_W'(ONE_Q16));
    end
  end

  assign out_valid        = out_valid_r;
  assign out_source_index = out_idx_r;
  assign out_last_out     = out_last_r;

endmodule

### sim/tb_top.sv
// Self-checking testbench for the systematic resampler: predictor, stimulus and checks.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import sysres_pkg::*;

  // Cycles without any transfer on any channel before the run is declared hung.
  // The longest correct stretch is a pointer walk across all 64 entries before a
  // slot is emitted, plus a receiver stall, so this leaves a wide margin.
  localparam int HANG_LIMIT   = 2000;
  // Cycles allowed for the sequencer to return to idle after its last result.
  localparam int SETTLE_CYCLES = 10;
  localparam int RANDOM_ITEMS  = 420;
  localparam int MAX_GAP       = 13;
  localparam int IDX_W         = $clog2(MAX_PARTICLES_DEF);

  // One resampled output slot as the block presents it.
  typedef struct packed {
    logic [SRC_W-1:0] source_index;
    logic             last_out;
  } slot_t;

  // Scoreboard: a bit-exact model of the loader and the pointer walk, and the
  // queue of output slots it has predicted but not yet seen.
  class resample_scoreboard;
    logic [SUM_W-1:0] cum_sum [MAX_PARTICLES_DEF];
    int unsigned      load_count = 0;
    int unsigned      walk_ptr   = 0;
    logic [CFG_W-1:0] count_reg  = CFG_W'(COUNT_RESET);
    slot_t            expected_slots [$];
    int               errors   = 0;
    int               reported = 0;

    function void set_count(logic [CFG_W-1:0] value);
      count_reg = value;
    endfunction

    function int unsigned active_count();
      int unsigned n;
      n = 32'(count_reg);
      if (n == 0) n = 1;
      if (n > MAX_PARTICLES_DEF) n = MAX_PARTICLES_DEF;
      return n;
    endfunction

    function int pending();
      return expected_slots.size();
    endfunction

    // Applies one accepted weight transfer. Returns 1 when the weight was stored,
    // 0 when the set was already full and the weight was dropped.
    function bit note_weight(logic [WEIGHT_W-1:0] weight, logic [DRAW_W-1:0] draw,
                             logic last_in);
      int unsigned      n;
      int unsigned      used;
      int unsigned      idx;
      logic [SUM_W-1:0] prev;
      logic [WEIGHT_W-1:0] w;
      longint           threshold;
      longint           scaled;
      bit               stored;
      slot_t            slot;
      n      = active_count();
      w      = (weight > ONE_Q16) ? WEIGHT_W'(ONE_Q16) : weight;
      stored = 1'b0;
      if (load_count < n) begin
        prev = (load_count == 0) ? '0 : cum_sum[IDX_W'(load_count - 1)];
        cum_sum[IDX_W'(load_count)] = prev + SUM_W'(w);
        load_count++;
        stored = 1'b1;
      end
      if (last_in) begin
        // Only entries written in this set are read; a short set repeats the sum
        // of its final weight, so the missing weights count as zero.
        used = (load_count < n) ? load_count : n;
        walk_ptr = 0;
        for (int unsigned j = 0; j < n; j++) begin
          threshold = longint'(draw) - HALF_Q16 + longint'(j) * ONE_Q16;
          forever begin
            idx    = (walk_ptr < used) ? walk_ptr : used - 1;
            scaled = longint'(n) * longint'(cum_sum[IDX_W'(idx)]);
            if (!(threshold > scaled && walk_ptr < n - 1)) break;
            walk_ptr++;
          end
          slot.source_index = SRC_W'(walk_ptr);
          slot.last_out     = (j == n - 1);
          expected_slots.push_back(slot);
        end
        load_count = 0;
      end
      return stored;
    endfunction

    // Compares one accepted output transfer with the oldest predicted slot.
    function void check_slot(logic [SRC_W-1:0] source_index, logic last_out);
      slot_t want;
      if (expected_slots.size() == 0) begin
        errors++;
        if (reported < 10) begin
          reported++;
          $display("ERROR: unexpected result source_index=%0d last_out=%0b",
                   source_index, last_out);
        end
      end else begin
        want = expected_slots.pop_front();
        if (want.source_index !== source_index || want.last_out !== last_out) begin
          errors++;
          if (reported < 10) begin
            reported++;
            $display("ERROR: source_index expected %0d got %0d, last_out expected %0b got %0b",
                     want.source_index, source_index, want.last_out, last_out);
          end
        end
      end
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [WEIGHT_W-1:0] in_weight = '0;
  logic [DRAW_W-1:0]   in_draw = '0;
  logic                in_last_in = 1'b0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [SRC_W-1:0]    out_source_index;
  logic                out_last_out;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [CFG_W-1:0]    cfg_particle_count = '0;

  resample_scoreboard sb = new;

  // While quiet is set, neither side inserts idle cycles.
  bit quiet = 1'b0;
  int stored_items = 0;

  systematic_resampler u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_weight         (in_weight),
    .in_draw           (in_draw),
    .in_last_in        (in_last_in),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_source_index  (out_source_index),
    .out_last_out      (out_last_out),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_particle_count(cfg_particle_count)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Draws the idle cycles a side waits before its next transfer.
  function int pick_gap();
    return quiet ? 0 : $urandom_range(0, MAX_GAP);
  endfunction

  // Sends one weight transfer. The valid is only lowered when a gap follows, so
  // back-to-back transfers keep it high without a second assignment in one step.
  // Signals are sampled right after the edge, before any update of that edge.
  task automatic send_weight(input logic [WEIGHT_W-1:0] weight,
                             input logic [DRAW_W-1:0] draw, input logic last_in);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_weight  <= weight;
    in_draw    <= draw;
    in_last_in <= last_in;
    do @(posedge clk); while (in_stall);
    if (sb.note_weight(weight, draw, last_in)) stored_items++;
  endtask

  // Holds the sender off until every predicted slot has arrived and the
  // sequencer has had time to settle back to idle.
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Writes the particle count register while the block is idle.
  task automatic write_count(input logic [CFG_W-1:0] value);
    drain();
    cfg_valid          <= 1'b1;
    cfg_particle_count <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    sb.set_count(value);
  endtask

  // Sends a complete set of len weights; the final one carries the draw.
  // Noisy sets use arbitrary 17-bit weights, the others share roughly one.
  task automatic send_set(input int len, input bit noisy);
    int unsigned share;
    int unsigned w;
    share = ONE_Q16 / len;
    for (int k = 0; k < len; k++) begin
      if (noisy) w = $urandom_range(0, (1 << WEIGHT_W) - 1);
      else w = $urandom_range(0, 2 * share);
      if (!noisy && w > ONE_Q16) w = ONE_Q16;
      send_weight(WEIGHT_W'(w), DRAW_W'($urandom_range(0, 65535)), k == len - 1);
    end
  endtask

  // Result side: stalls for a random number of cycles before each transfer
  // and checks every accepted slot against the oldest prediction.
  initial begin
    int gap;
    @(posedge rst_n);
    forever begin
      gap = pick_gap();
      if (gap > 0) begin
        out_stall <= 1'b1;
        repeat (gap) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
      sb.check_slot(out_source_index, out_last_out);
    end
  end

  // Watchdog: any transfer on any channel restarts the count.
  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < HANG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("Verification failed");
    $finish;
  end

  // Main stimulus sequence.
  initial begin
    int unsigned n;
    int          len;
    int          kind;
    int          sets;
    int unsigned pick;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset count of 64 with a single full weight and the lowest draw: a very
    // short set, so every later slot sees the same sum.
    send_weight(WEIGHT_W'(ONE_Q16), '0, 1'b1);

    // One particle, zero weight and the highest draw.
    write_count(CFG_W'(1));
    send_weight('0, '1, 1'b1);

    // Four particles with an oversized weight that must saturate to one.
    write_count(CFG_W'(4));
    send_weight('1, '0, 1'b0);
    send_weight('0, '1, 1'b0);
    send_weight(WEIGHT_W'(ONE_Q16), '0, 1'b0);
    send_weight(WEIGHT_W'(1), DRAW_W'(HALF_Q16), 1'b1);

    // Three particles but five weights: the two extra weights are dropped and
    // the last one still starts the walk with its draw.
    write_count(CFG_W'(3));
    for (int k = 0; k < 5; k++)
      send_weight(WEIGHT_W'(20000), DRAW_W'(65535 - k), k == 4);

    // Eight particles but only three weights.
    write_count(CFG_W'(8));
    send_weight(WEIGHT_W'(ONE_Q16), DRAW_W'(12345), 1'b0);
    send_weight('0, DRAW_W'(1), 1'b0);
    send_weight('0, DRAW_W'(40000), 1'b1);

    // Count lowered in the middle of a load: only the first two entries count.
    send_weight(WEIGHT_W'(10000), '0, 1'b0);
    send_weight(WEIGHT_W'(30000), '0, 1'b0);
    send_weight(WEIGHT_W'(5000), '0, 1'b0);
    send_weight(WEIGHT_W'(20000), '0, 1'b0);
    send_weight(WEIGHT_W'(500), '0, 1'b0);
    write_count(CFG_W'(2));
    send_weight(WEIGHT_W'(500), DRAW_W'(50000), 1'b1);

    // A count of zero acts as one.
    write_count('0);
    send_weight(WEIGHT_W'(30000), DRAW_W'(100), 1'b0);
    send_weight(WEIGHT_W'(30000), DRAW_W'(60000), 1'b1);

    // The largest count code acts as the full 64 particles.
    write_count('1);
    send_weight(WEIGHT_W'(ONE_Q16 - 1), DRAW_W'(65000), 1'b1);

    // Random part: mostly well-formed sets with random weights and draws,
    // mixed with short, overlong and noisy sets and occasional count changes.
    stored_items = 0;
    sets = 0;
    while (stored_items < RANDOM_ITEMS) begin
      quiet = ($urandom_range(0, 5) == 0);
      if (sets == 0 || $urandom_range(0, 3) == 0) begin
        pick = $urandom_range(0, 99);
        if (pick < 70)      write_count(CFG_W'($urandom_range(1, 8)));
        else if (pick < 85) write_count(CFG_W'($urandom_range(9, MAX_PARTICLES_DEF)));
        else if (pick < 95) write_count(CFG_W'($urandom_range(MAX_PARTICLES_DEF + 1, 127)));
        else                write_count('0);
      end else if ($urandom_range(0, 4) == 0) begin
        drain();
      end
      n = sb.active_count();
      kind = $urandom_range(0, 9);
      if (kind <= 6)      len = n;
      else if (kind == 7) len = $urandom_range(1, n);
      else if (kind == 8) len = n + $urandom_range(1, 3);
      else                len = $urandom_range(1, n + 2);
      send_set(len, kind == 9);
      sets++;
    end

    quiet = 1'b0;
    drain();
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
